// ===== src/crng_pkg.sv =====
// ----------------------------------------------------------------------------
// crng_pkg: shared types and constants of the counter-mode random generator
// Block layout constants, config register indexes and the rotate helper.
// ----------------------------------------------------------------------------
package crng_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  localparam int CFG_INDEX_W = 8;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_SEED_KEY = cfg_index_t'(0);
  localparam cfg_index_t CFG_MIX_KEY  = cfg_index_t'(1);

  // "expand 32-byte k"
  localparam word_t SIGMA0 = 32'h61707865;
  localparam word_t SIGMA1 = 32'h3320646e;
  localparam word_t SIGMA2 = 32'h79622d32;
  localparam word_t SIGMA3 = 32'h6b206574;

  // fixed key words 8..11
  localparam word_t FIXED_KEY0 = 32'h9E3779B9;
  localparam word_t FIXED_KEY1 = 32'h7F4A7C15;
  localparam word_t FIXED_KEY2 = 32'h85EBCA6B;
  localparam word_t FIXED_KEY3 = 32'hC2B2AE35;

  // nonce words 14, 15
  localparam word_t NONCE0 = 32'h12345678;
  localparam word_t NONCE1 = 32'h9ABCDEF0;

  // add-xor-rotate steps per double round
  localparam int STEPS_PER_DR = 8;

  function automatic word_t rotl32(input word_t v, input int n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

endpackage

// ===== src/crng_ifs.sv =====
// ----------------------------------------------------------------------------
// crng_ifs: channel interfaces of the counter-mode random generator
// Request, response and config write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface crng_req_if;
  logic valid;
  logic ready;
  logic request;

  modport source (output valid, output request, input ready);
  modport sink   (input valid, input request, output ready);
endinterface

interface crng_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface crng_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [crng_pkg::CFG_INDEX_W-1:0] index;
  logic [63:0]               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/crng_cell.sv =====
// ----------------------------------------------------------------------------
// crng_cell: one add-xor-rotate step of a ChaCha double round
// Applies one step to all four quarter rounds and registers the block.
// ----------------------------------------------------------------------------
module crng_cell #(
  parameter int STEP = 0   // 0..7 within a double round
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  crng_pkg::block_t in_block,
  output logic             out_valid,
  output crng_pkg::block_t out_block
);

  localparam bit DIAG = (STEP / 4) == 1;
  localparam int SUB  = STEP % 4;
  localparam int ROT  = (SUB == 0) ? 16 : (SUB == 1) ? 12 : (SUB == 2) ? 8 : 7;

  crng_pkg::block_t blk_next;

  always_comb begin
    logic [3:0] ia, ib, ic, id;
    blk_next = in_block;
    for (int q = 0; q < 4; q++) begin
      ia = 4'(q);
      ib = DIAG ? 4'(4 + ((q + 1) % 4))  : 4'(4 + q);
      ic = DIAG ? 4'(8 + ((q + 2) % 4))  : 4'(8 + q);
      id = DIAG ? 4'(12 + ((q + 3) % 4)) : 4'(12 + q);
      if (SUB == 0 || SUB == 2) begin
        // a += b; d = (d ^ a) <<< r
        blk_next[ia] = in_block[ia] + in_block[ib];
        blk_next[id] = crng_pkg::rotl32(in_block[id] ^ blk_next[ia], ROT);
      end else begin
        // c += d; b = (b ^ c) <<< r
        blk_next[ic] = in_block[ic] + in_block[id];
        blk_next[ib] = crng_pkg::rotl32(in_block[ib] ^ blk_next[ic], ROT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_block <= blk_next;
    end
  end

endmodule

// ===== src/chacha20_counter_rng.sv =====
// ----------------------------------------------------------------------------
// chacha20_counter_rng: counter-mode random generator on ChaCha20
// Fully pipelined block function, one 64-bit word out per cycle while rsp takes each word.
// ----------------------------------------------------------------------------
// Usage:
//   cfg : write channel, always ready. Index CFG_SEED_KEY sets the seed
//         (key words 4,5), CFG_MIX_KEY the mixing seed (key words 6,7).
//         Other indexes are ignored. Seeds are latched by the first request
//         after reset; later writes have no effect until the next reset.
//   req : one word per request. A word with request = 0 is taken and dropped.
//   rsp : random_word = block words 0 (low) and 1 (high) of the ChaCha20 block
//         for the current 64-bit counter, which then steps by one (wraps).
// Path: an accepted request passes through one cell per add-xor-rotate step,
//   then through the output register, before rsp can take the word.
// Throughput: one word per cycle while rsp takes each word; only the counter links successive words.
// Stall: the whole chain advances together; when rsp holds a word that is not
//   taken, req.ready drops and every stage holds. No word is lost.
// Reset: rst (sync) clears valid bits, the counter, the started flag and the
//   seed registers; the pipeline is empty right after reset.
// ----------------------------------------------------------------------------
module chacha20_counter_rng #(
  parameter int DOUBLE_ROUNDS = 10   // 1..10
) (
  input logic        clk,
  input logic        rst,
  crng_req_if.sink   req,
  crng_rsp_if.source rsp,
  crng_cfg_if.sink   cfg
);

  localparam int NSTAGE = DOUBLE_ROUNDS * crng_pkg::STEPS_PER_DR;

  // config registers
  logic [63:0] seed_key;
  logic [63:0] mix_key;

  // key schedule state
  logic        started;
  logic [63:0] key_lo;    // key words 4,5
  logic [63:0] key_hi;    // key words 6,7
  logic [63:0] cnt;

  logic        en;
  logic        take;
  logic [63:0] cur_lo, cur_hi, cur_cnt;

  logic             link_valid [NSTAGE+1];
  crng_pkg::block_t link_block [NSTAGE+1];

  logic        out_valid;
  logic [63:0] out_word;

  // whole chain moves when the output register is free or being drained
  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;
  assign take      = req.valid && en && req.request;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_key <= '0;
      mix_key  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        crng_pkg::CFG_SEED_KEY: seed_key <= cfg.data;
        crng_pkg::CFG_MIX_KEY:  mix_key  <= cfg.data;
        default: ;
      endcase
    end
  end

  // first request uses the seed registers and counter zero directly
  assign cur_lo  = started ? key_lo : seed_key;
  assign cur_hi  = started ? key_hi : mix_key;
  assign cur_cnt = started ? cnt    : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      cnt     <= '0;
    end else if (take) begin
      started <= 1'b1;
      cnt     <= cur_cnt + 64'd1;
    end
  end

  // key words: undefined until latched, so no reset
  always_ff @(posedge clk) begin
    if (take && !started) begin
      key_lo <= seed_key;
      key_hi <= mix_key;
    end
  end

  // input block, word 15 first
  assign link_valid[0] = req.valid && req.request;
  assign link_block[0] = {crng_pkg::NONCE1,     crng_pkg::NONCE0,
                          cur_cnt[63:32],       cur_cnt[31:0],
                          crng_pkg::FIXED_KEY3, crng_pkg::FIXED_KEY2,
                          crng_pkg::FIXED_KEY1, crng_pkg::FIXED_KEY0,
                          cur_hi[63:32],        cur_hi[31:0],
                          cur_lo[63:32],        cur_lo[31:0],
                          crng_pkg::SIGMA3,     crng_pkg::SIGMA2,
                          crng_pkg::SIGMA1,     crng_pkg::SIGMA0};

  // chain of step cells: column round steps 0..3, diagonal round steps 4..7
  for (genvar k = 0; k < NSTAGE; k++) begin : g_cell
    crng_cell #(
      .STEP (k % crng_pkg::STEPS_PER_DR)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (link_valid[k]),
      .in_block  (link_block[k]),
      .out_valid (link_valid[k+1]),
      .out_block (link_block[k+1])
    );
  end

  // feed-forward add: input words 0,1 are the sigma constants
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= link_valid[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= {link_block[NSTAGE][1] + crng_pkg::SIGMA1,
                   link_block[NSTAGE][0] + crng_pkg::SIGMA0};
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;

  // a held output word blocks new requests
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |-> !req.ready)
    else $error("request accepted while output stalled");

  // any accepted request marks the keys as latched
  a_start_latch: assert property (@(posedge clk) disable iff (rst)
    take |=> started)
    else $error("started not set after request");

  // counter steps by one per accepted request once started
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    take && started |=> cnt == $past(cnt) + 64'd1)
    else $error("block counter did not step");

  // counter holds when nothing is taken
  a_counter_hold: assert property (@(posedge clk) disable iff (rst)
    !take && started |=> cnt == $past(cnt))
    else $error("block counter moved without a request");

endmodule
